// ----- rtl/ipv4hc_pkg.sv -----
// Shared constants, status codes and result type of the IPv4 header checker.
package ipv4hc_pkg;

    // Header geometry and the only accepted version / header length
    localparam int unsigned HDR_BYTES   = 20;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned IP_VERSION  = 4;
    localparam int unsigned IP_IHL      = 5;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_CSUM_ERR  = 2'd2;
    localparam logic [1:0] STATUS_LEN_ERR   = 2'd3;

    // Header byte positions that carry fields
    localparam logic [4:0] IDX_VER_IHL  = 5'd0;
    localparam logic [4:0] IDX_TLEN_HI  = 5'd2;
    localparam logic [4:0] IDX_TLEN_LO  = 5'd3;
    localparam logic [4:0] IDX_IDENT_HI = 5'd4;
    localparam logic [4:0] IDX_IDENT_LO = 5'd5;
    localparam logic [4:0] IDX_FRAG_HI  = 5'd6;
    localparam logic [4:0] IDX_FRAG_LO  = 5'd7;
    localparam logic [4:0] IDX_TTL      = 5'd8;
    localparam logic [4:0] IDX_PROTO    = 5'd9;
    localparam logic [4:0] IDX_SRC_0    = 5'd12;
    localparam logic [4:0] IDX_SRC_3    = 5'd15;
    localparam logic [4:0] IDX_DST_0    = 5'd16;
    localparam logic [4:0] IDX_DST_3    = 5'd19;

    // One packet verdict with the latched header fields
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] ident;
        logic [15:0] frag_flags_offset;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [7:0]  protocol_number;
        logic [7:0]  time_to_live;
    } result_t;

endpackage

// ----- rtl/ipv4hc_core.sv -----
// Per-packet header state: byte count, checksum accumulator, field latches and verdict.
module ipv4hc_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,     // consume the held byte this cycle
    input  logic [7:0]            data_byte,
    input  logic                  last,
    output ipv4hc_pkg::result_t   result       // verdict if the held byte is the last
);

    logic [ipv4hc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  verlen_reg, verlen_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [15:0] ident_reg, ident_next;
    logic [15:0] frag_reg, frag_next;
    logic [7:0]  ttl_reg, ttl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;

    logic        in_header;
    logic [4:0]  idx;
    logic [16:0] sum_wide;
    logic [15:0] sum_folded;
    logic        bad_form;

    assign idx       = count_reg[4:0];
    assign in_header = (count_reg < ipv4hc_pkg::COUNT_W'(ipv4hc_pkg::HDR_BYTES));

    // Add one big-endian word with end-around carry
    assign sum_wide   = {1'b0, sum_reg} + {1'b0, hold_reg, data_byte};
    assign sum_folded = sum_wide[15:0] + {15'd0, sum_wide[16]};

    // Advance header state with the held byte
    always_comb begin
        count_next  = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        sum_next    = sum_reg;
        hold_next   = hold_reg;
        verlen_next = verlen_reg;
        tlen_next   = tlen_reg;
        ident_next  = ident_reg;
        frag_next   = frag_reg;
        ttl_next    = ttl_reg;
        proto_next  = proto_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        if (in_header) begin
            if (idx[0] == 1'b0) begin
                hold_next = data_byte;
            end else begin
                sum_next = sum_folded;
            end
            if (idx >= ipv4hc_pkg::IDX_SRC_0 && idx <= ipv4hc_pkg::IDX_SRC_3) begin
                src_next = {src_reg[23:0], data_byte};
            end
            if (idx >= ipv4hc_pkg::IDX_DST_0 && idx <= ipv4hc_pkg::IDX_DST_3) begin
                dst_next = {dst_reg[23:0], data_byte};
            end
            case (idx)
                ipv4hc_pkg::IDX_VER_IHL:  verlen_next = data_byte;
                ipv4hc_pkg::IDX_TLEN_HI:  tlen_next   = {data_byte, tlen_reg[7:0]};
                ipv4hc_pkg::IDX_TLEN_LO:  tlen_next   = {tlen_reg[15:8], data_byte};
                ipv4hc_pkg::IDX_IDENT_HI: ident_next  = {data_byte, ident_reg[7:0]};
                ipv4hc_pkg::IDX_IDENT_LO: ident_next  = {ident_reg[15:8], data_byte};
                ipv4hc_pkg::IDX_FRAG_HI:  frag_next   = {data_byte, frag_reg[7:0]};
                ipv4hc_pkg::IDX_FRAG_LO:  frag_next   = {frag_reg[15:8], data_byte};
                ipv4hc_pkg::IDX_TTL:      ttl_next    = data_byte;
                ipv4hc_pkg::IDX_PROTO:    proto_next  = data_byte;
                default: ;
            endcase
        end
    end

    // Judge the packet from the state including this byte
    assign bad_form =
        (count_next < ipv4hc_pkg::COUNT_W'(ipv4hc_pkg::HDR_BYTES)) ||
        (verlen_next[7:4] != 4'(ipv4hc_pkg::IP_VERSION)) ||
        (verlen_next[3:0] != 4'(ipv4hc_pkg::IP_IHL));

    always_comb begin
        result = '0;
        if (bad_form) begin
            result.status = ipv4hc_pkg::STATUS_MALFORMED;
        end else if (sum_next != 16'hFFFF) begin
            result.status = ipv4hc_pkg::STATUS_CSUM_ERR;
        end else if (tlen_next < 16'(ipv4hc_pkg::HDR_BYTES) || tlen_next > count_next) begin
            result.status = ipv4hc_pkg::STATUS_LEN_ERR;
        end else begin
            result.status              = ipv4hc_pkg::STATUS_OK;
            result.ident               = ident_next;
            result.frag_flags_offset   = frag_next;
            result.source_address      = src_next;
            result.destination_address = dst_next;
            result.protocol_number     = proto_next;
            result.time_to_live        = ttl_next;
        end
    end

    // Hold state; clear it on reset and after the last byte of a packet
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && last)) begin
            count_reg  <= '0;
            sum_reg    <= '0;
            hold_reg   <= '0;
            verlen_reg <= '0;
            tlen_reg   <= '0;
            ident_reg  <= '0;
            frag_reg   <= '0;
            ttl_reg    <= '0;
            proto_reg  <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
        end else if (advance) begin
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            hold_reg   <= hold_next;
            verlen_reg <= verlen_next;
            tlen_reg   <= tlen_next;
            ident_reg  <= ident_next;
            frag_reg   <= frag_next;
            ttl_reg    <= ttl_next;
            proto_reg  <= proto_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
        end
    end

endmodule

// ----- rtl/ipv4_header_checker.sv -----
// Top level of the IPv4 header checker: input register, header core, result register.
//
//  channel | dir | tdata                         | tuser       | tlast
//  s_      | in  | data_byte[7:0]                | -           | last
//  m_      | out | ident, frag, src, dst, proto, ttl | status[1:0] | -
//
// One byte is taken per cycle unless a held last byte waits on a stalled m_ side;
// each byte waits in the input register, and a packet's verdict is registered in
// the result register before it appears on m_.
// The header core updates its sums and field latches as it consumes each held byte.
// Reset (aresetn low at a clock edge) empties both registers and clears the
// packet state. A stalled m_ side holds its result and backs up into s_ only
// when a second last byte arrives before the first result is taken.
module ipv4_header_checker (
    input  logic          aclk,
    input  logic          aresetn,
    // received bytes
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,    // [7:0] data_byte
    input  logic          s_tlast,    // last
    // packet verdicts
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,    // [15:0] ident, [31:16] frag_flags_offset,
                                      // [63:32] source_address,
                                      // [95:64] destination_address,
                                      // [103:96] protocol_number,
                                      // [111:104] time_to_live
    output logic [1:0]    m_tuser     // [1:0] status
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg;
    ipv4hc_pkg::result_t  out_reg;
    ipv4hc_pkg::result_t  verdict;
    logic                 advance;

    // Consume the held byte unless it would produce a result that cannot land
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ipv4hc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .last      (in_last_reg),
        .result    (verdict)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {out_reg.time_to_live, out_reg.protocol_number,
                       out_reg.destination_address, out_reg.source_address,
                       out_reg.frag_flags_offset, out_reg.ident};

endmodule
